FILE: hw/rtl/pjb_pkg.sv
// Package of the packet jitter buffer: queue item and result types, status
// and operation codes, back-end state encoding and the fixed field widths.
// No dependencies; used by pjb_front, pjb_back and packet_jitter_buffer.
package pjb_pkg;

  localparam int SEQ_W    = 16;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 7;
  localparam int STATUS_W = 3;

  // Command field encoding.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_LAST,
    OP_POP
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_BYTE    = 3'd0,
    STATUS_CONCEAL = 3'd1,
    STATUS_NONE    = 3'd2,
    STATUS_STORED  = 3'd3,
    STATUS_REJECT  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MOD_MUL,
    BK_MOD_FIX,
    BK_STORE,
    BK_PLAY,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [SEQ_W-1:0]  seq;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef struct packed {
    status_e           status;
    logic [BYTE_W-1:0] out_byte;
    logic [LEN_W-1:0]  length;
    logic [SEQ_W-1:0]  frame_seq;
    logic              final_res;
  } result_t;

endpackage

FILE: hw/rtl/pjb_front.sv
// Front end of the packet jitter buffer: accepts input transfers, classifies
// each as a packet byte, a final packet byte or a pop, and queues it.
// Depends on pjb_pkg.
module pjb_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cmd_i,
  input  logic [pjb_pkg::SEQ_W-1:0]    seq_i,
  input  logic [pjb_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic                         last_i,
  output logic                         item_valid_o,
  output pjb_pkg::item_t               item_o,
  input  logic                         item_pop_i
);

  pjb_pkg::item_t                   queue_q [pjb_pkg::QUEUE_DEPTH];
  logic [pjb_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [pjb_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [pjb_pkg::QCNT_W-1:0]       count_q, count_d;
  pjb_pkg::item_t                   new_item;
  logic                             push;
  logic                             pop;

  assign in_ready_o   = (count_q != pjb_pkg::QCNT_W'(pjb_pkg::QUEUE_DEPTH));
  assign item_valid_o = (count_q != '0);
  assign item_o       = queue_q[rd_ptr_q];
  assign push         = in_valid_i & in_ready_o;
  assign pop          = item_pop_i & item_valid_o;

  always_comb begin
    new_item.seq  = seq_i;
    new_item.data = data_byte_i;
    if (cmd_i == pjb_pkg::CMD_POP) begin
      new_item.op = pjb_pkg::OP_POP;
    end else if (last_i) begin
      new_item.op = pjb_pkg::OP_LAST;
    end else begin
      new_item.op = pjb_pkg::OP_BYTE;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == pjb_pkg::QPTR_W'(pjb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == pjb_pkg::QPTR_W'(pjb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

FILE: hw/rtl/pjb_back.sv
// Back end of the packet jitter buffer: slot table, packet byte store,
// playback sequencer and output register.
// Depends on pjb_pkg; fed by pjb_front through its queue.
module pjb_back #(
  parameter int SLOTS     = 16,
  parameter int MAX_BYTES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  pjb_pkg::item_t   item_i,
  output logic             item_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pjb_pkg::result_t out_o
);

  localparam int SW    = $clog2(SLOTS);
  localparam int BW    = $clog2(SLOTS + 1);
  localparam int FW    = $clog2(MAX_BYTES + 1);
  localparam int IW    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int DEPTH = (SLOTS + 1) * MAX_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = pjb_pkg::SEQ_W + BW;
  // Floor reciprocal of SLOTS; the quotient estimate is at most one low.
  localparam int RECIP_SHIFT = 24;
  localparam int PW          = pjb_pkg::SEQ_W + RECIP_SHIFT;
  localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'((1 << RECIP_SHIFT) / SLOTS);
  localparam logic [AW-1:0]          MAX_A = AW'(MAX_BYTES);

  pjb_pkg::back_state_e state_q, state_d;

  logic                        slot_valid_q [SLOTS];
  logic                        slot_valid_d [SLOTS];
  logic [BW-1:0]               slot_map_q   [SLOTS];
  logic [BW-1:0]               slot_map_d   [SLOTS];
  logic [pjb_pkg::SEQ_W-1:0]   slot_seq_q   [SLOTS];
  logic [pjb_pkg::SEQ_W-1:0]   slot_seq_d   [SLOTS];
  logic [FW-1:0]               slot_len_q   [SLOTS];
  logic [FW-1:0]               slot_len_d   [SLOTS];

  logic [BW-1:0]               spare_q, spare_d;
  logic [FW-1:0]               fill_q, fill_d;
  logic                        ovf_q, ovf_d;
  logic                        started_q, started_d;
  logic [pjb_pkg::SEQ_W-1:0]   play_seq_q, play_seq_d;
  logic [SW-1:0]               play_slot_q, play_slot_d;
  logic [pjb_pkg::SEQ_W-1:0]   cur_seq_q, cur_seq_d;
  logic [pjb_pkg::SEQ_W-1:0]   quot_q, quot_d;
  logic [SW-1:0]               slot_q, slot_d;
  logic [FW-1:0]               play_idx_q, play_idx_d;
  logic [FW-1:0]               play_len_q, play_len_d;
  pjb_pkg::result_t            res_q, res_d;
  logic                        out_valid_q, out_valid_d;
  pjb_pkg::result_t            out_q, out_d;

  logic [pjb_pkg::BYTE_W-1:0]  mem_q [DEPTH];
  logic [pjb_pkg::BYTE_W-1:0]  rdata_q;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [pjb_pkg::BYTE_W-1:0]  mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;

  logic                        out_free;
  logic                        exp_hit;
  logic                        future_hit;
  logic [pjb_pkg::SEQ_W-1:0]   adv_seq;
  logic [SW-1:0]               adv_slot;
  logic [AW-1:0]               play_base;
  logic [PW-1:0]               prod;
  logic [MW-1:0]               rem_raw;
  logic [MW-1:0]               rem_fix;
  logic                        play_last;

  assign out_free  = !out_valid_q || out_ready_i;
  assign exp_hit   = slot_valid_q[play_slot_q] && (slot_seq_q[play_slot_q] == play_seq_q);
  assign adv_seq   = play_seq_q + 1'b1;
  // Slot index follows the sequence, including the wrap of the 16-bit count.
  assign adv_slot  = ((play_seq_q == '1) || (play_slot_q == SW'(SLOTS - 1))) ? '0
                                                                             : play_slot_q + 1'b1;
  assign play_base = AW'(slot_map_q[play_slot_q]) * MAX_A;
  assign prod      = PW'(cur_seq_q) * PW'(RECIP);
  assign rem_raw   = MW'(cur_seq_q) - MW'(quot_q) * MW'(SLOTS);
  assign rem_fix   = (rem_raw >= MW'(SLOTS)) ? rem_raw - MW'(SLOTS) : rem_raw;
  assign play_last = ((play_idx_q + 1'b1) == play_len_q);

  // Every stored sequence sits in its own slot, so a later packet is waiting
  // exactly when some valid slot is 1 to SLOTS-1 ahead of the awaited one.
  always_comb begin
    logic [pjb_pkg::SEQ_W-1:0] diff;
    future_hit = 1'b0;
    diff       = '0;
    for (int j = 0; j < SLOTS; j++) begin
      diff = slot_seq_q[j] - play_seq_q;
      if (slot_valid_q[j] && (diff != '0) && (diff < pjb_pkg::SEQ_W'(SLOTS))) begin
        future_hit = 1'b1;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    slot_valid_d = slot_valid_q;
    slot_map_d   = slot_map_q;
    slot_seq_d   = slot_seq_q;
    slot_len_d   = slot_len_q;
    spare_d      = spare_q;
    fill_d       = fill_q;
    ovf_d        = ovf_q;
    started_d    = started_q;
    play_seq_d   = play_seq_q;
    play_slot_d  = play_slot_q;
    cur_seq_d    = cur_seq_q;
    quot_d       = quot_q;
    slot_d       = slot_q;
    play_idx_d   = play_idx_q;
    play_len_d   = play_len_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_ready_i ? 1'b0 : out_valid_q;
    item_pop_o   = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = AW'(spare_q) * MAX_A + AW'(fill_q[IW-1:0]);
    mem_wdata    = item_i.data;
    mem_re       = 1'b0;
    mem_raddr    = play_base;

    case (state_q)
      pjb_pkg::BK_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          case (item_i.op)
            pjb_pkg::OP_BYTE, pjb_pkg::OP_LAST: begin
              if (fill_q < FW'(MAX_BYTES)) begin
                mem_we = 1'b1;
                fill_d = fill_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
              if (item_i.op == pjb_pkg::OP_LAST) begin
                cur_seq_d = item_i.seq;
                if (ovf_q || (fill_q == FW'(MAX_BYTES))) begin
                  res_d   = '{status: pjb_pkg::STATUS_REJECT, out_byte: '0, length: '0,
                              frame_seq: item_i.seq, final_res: 1'b1};
                  fill_d  = '0;
                  ovf_d   = 1'b0;
                  state_d = pjb_pkg::BK_EMIT;
                end else begin
                  state_d = pjb_pkg::BK_MOD_MUL;
                end
              end
            end
            pjb_pkg::OP_POP: begin
              if (started_q && exp_hit) begin
                if (slot_len_q[play_slot_q] == '0) begin
                  res_d = '{status: pjb_pkg::STATUS_BYTE, out_byte: '0, length: '0,
                            frame_seq: play_seq_q, final_res: 1'b1};
                  slot_valid_d[play_slot_q] = 1'b0;
                  play_seq_d  = adv_seq;
                  play_slot_d = adv_slot;
                  state_d     = pjb_pkg::BK_EMIT;
                end else begin
                  mem_re     = 1'b1;
                  play_idx_d = '0;
                  play_len_d = slot_len_q[play_slot_q];
                  state_d    = pjb_pkg::BK_PLAY;
                end
              end else if (started_q && future_hit) begin
                res_d = '{status: pjb_pkg::STATUS_CONCEAL, out_byte: '0, length: '0,
                          frame_seq: play_seq_q, final_res: 1'b1};
                play_seq_d  = adv_seq;
                play_slot_d = adv_slot;
                state_d     = pjb_pkg::BK_EMIT;
              end else begin
                res_d = '{status: pjb_pkg::STATUS_NONE, out_byte: '0, length: '0,
                          frame_seq: play_seq_q, final_res: 1'b1};
                state_d = pjb_pkg::BK_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      pjb_pkg::BK_MOD_MUL: begin
        quot_d  = prod[PW-1:RECIP_SHIFT];
        state_d = pjb_pkg::BK_MOD_FIX;
      end
      pjb_pkg::BK_MOD_FIX: begin
        slot_d  = SW'(rem_fix);
        state_d = pjb_pkg::BK_STORE;
      end
      pjb_pkg::BK_STORE: begin
        // The finished buffer takes the slot; the slot's old buffer becomes spare.
        spare_d            = slot_map_q[slot_q];
        slot_map_d[slot_q] = spare_q;
        slot_valid_d[slot_q] = 1'b1;
        slot_seq_d[slot_q] = cur_seq_q;
        slot_len_d[slot_q] = fill_q;
        if (!started_q) begin
          started_d   = 1'b1;
          play_seq_d  = cur_seq_q;
          play_slot_d = slot_q;
        end
        res_d = '{status: pjb_pkg::STATUS_STORED, out_byte: '0,
                  length: pjb_pkg::LEN_W'(fill_q), frame_seq: cur_seq_q, final_res: 1'b1};
        fill_d  = '0;
        ovf_d   = 1'b0;
        state_d = pjb_pkg::BK_EMIT;
      end
      pjb_pkg::BK_PLAY: begin
        // rdata_q holds the current byte until the output register takes it.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{status: pjb_pkg::STATUS_BYTE, out_byte: rdata_q,
                    length: pjb_pkg::LEN_W'(play_len_q), frame_seq: play_seq_q,
                    final_res: play_last};
          play_idx_d = play_idx_q + 1'b1;
          if (play_last) begin
            slot_valid_d[play_slot_q] = 1'b0;
            play_seq_d  = adv_seq;
            play_slot_d = adv_slot;
            state_d     = pjb_pkg::BK_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = play_base + AW'(play_idx_d[IW-1:0]);
          end
        end
      end
      pjb_pkg::BK_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = pjb_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = pjb_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pjb_pkg::BK_IDLE;
      spare_q     <= BW'(SLOTS);
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      started_q   <= 1'b0;
      play_seq_q  <= '0;
      play_slot_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid_q[i] <= 1'b0;
        slot_map_q[i]   <= BW'(i);
      end
    end else begin
      state_q      <= state_d;
      spare_q      <= spare_d;
      fill_q       <= fill_d;
      ovf_q        <= ovf_d;
      started_q    <= started_d;
      play_seq_q   <= play_seq_d;
      play_slot_q  <= play_slot_d;
      out_valid_q  <= out_valid_d;
      slot_valid_q <= slot_valid_d;
      slot_map_q   <= slot_map_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_seq_q <= slot_seq_d;
    slot_len_q <= slot_len_d;
    cur_seq_q  <= cur_seq_d;
    quot_q     <= quot_d;
    slot_q     <= slot_d;
    play_idx_q <= play_idx_d;
    play_len_q <= play_len_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(MAX_BYTES))
    else $error("fill count exceeds the packet size limit");

  a_spare_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_q <= BW'(SLOTS))
    else $error("spare buffer index out of range");

  a_play_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pjb_pkg::BK_PLAY) |-> (started_q && slot_valid_q[play_slot_q]))
    else $error("playback from a slot that is not valid");

  a_pop_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> item_valid_i)
    else $error("queue popped while empty");

  a_emit_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == pjb_pkg::BK_EMIT) && out_free)
      |=> (out_valid_q && (state_q == pjb_pkg::BK_IDLE)))
    else $error("staged result not moved to the output register");

endmodule

FILE: hw/rtl/packet_jitter_buffer.sv
// Packet jitter buffer, top level: front end with its input queue, back end
// with slot table, byte store and playback sequencer.
// Depends on pjb_pkg, pjb_front and pjb_back.
//
// Usage: the input channel carries push bytes (cmd_i = 0, with seq_i,
// data_byte_i and last_i) and pops (cmd_i = 1). The output channel carries
// one result per transfer; final_res_o marks the last result of an item.
// A four-entry queue lets the input keep accepting while the back end works.
// Order of work, from when the back end takes an item from the queue:
//   - a push byte that is not the last gives no result;
//   - a last byte finds its slot index by reciprocal multiply and correction,
//     then commits and gives its stored result; a rejected one skips these steps;
//   - a pop is classified first; a played packet then streams one byte per
//     cycle while the receiver is ready, from the byte store's registered read
//     port, and concealment and nothing-to-play results are staged and emitted.
// Reset empties the queue, marks all slots invalid and restores the buffer
// map; the byte store is not cleared, so there is no clearing pass.
// When the receiver stalls, the output register holds its result, the back
// end waits, and the input stalls once the queue is full.
module packet_jitter_buffer #(
  parameter int SLOTS     = 16,
  parameter int MAX_BYTES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [pjb_pkg::SEQ_W-1:0]      seq_i,
  input  logic [pjb_pkg::BYTE_W-1:0]     data_byte_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pjb_pkg::STATUS_W-1:0]   status_o,
  output logic [pjb_pkg::BYTE_W-1:0]     out_byte_o,
  output logic [pjb_pkg::LEN_W-1:0]      length_o,
  output logic [pjb_pkg::SEQ_W-1:0]      frame_seq_o,
  output logic                           final_res_o
);

  logic             item_valid;
  logic             item_pop;
  pjb_pkg::item_t   item;
  pjb_pkg::result_t result;

  pjb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .seq_i        (seq_i),
    .data_byte_i  (data_byte_i),
    .last_i       (last_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  pjb_back #(
    .SLOTS     (SLOTS),
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (result)
  );

  assign status_o    = result.status;
  assign out_byte_o  = result.out_byte;
  assign length_o    = result.length;
  assign frame_seq_o = result.frame_seq;
  assign final_res_o = result.final_res;

endmodule
